// ----- rtl/fibonacci_mod_matrix_power_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Fibonacci mod matrix power unit: assertion macros
// Clocked implication checks shared by the unit's assertion section.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_MOD_MATRIX_POWER_UNIT_DEFINES_SVH
`define FIBONACCI_MOD_MATRIX_POWER_UNIT_DEFINES_SVH

// same-cycle implication
`define FMMP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FMMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fmmp_pkg.sv -----
// ----------------------------------------------------------------------------
// Fibonacci mod matrix power unit: package
// Sequencer state codes, matrix product modes and reset constants.
// ----------------------------------------------------------------------------
package fmmp_pkg;

   typedef logic [2:0] state_type;

   localparam state_type ST_IDLE   = 3'd0;
   localparam state_type ST_STEP   = 3'd1;
   localparam state_type ST_LOAD   = 3'd2;
   localparam state_type ST_MUL    = 3'd3;
   localparam state_type ST_ACCUM  = 3'd4;
   localparam state_type ST_COMMIT = 3'd5;
   localparam state_type ST_REDUCE = 3'd6;
   localparam state_type ST_FINISH = 3'd7;

   typedef logic mode_type;

   localparam mode_type MODE_MUL    = 1'b0;  // result = result * base
   localparam mode_type MODE_SQUARE = 1'b1;  // base = base * base

   localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

endpackage

// ----- rtl/fibonacci_mod_matrix_power_unit.sv -----
// ----------------------------------------------------------------------------
// Fibonacci mod matrix power unit
// Returns F(n) mod m by 2x2 matrix square-and-multiply on one serial
// modular multiplier.
// ----------------------------------------------------------------------------
// One index word in, one fib_value word out. The index is taken only while
// the sequencer is idle; a finished word may still wait on rsp_ready. All
// work runs on one shift-add modular multiplier that retires one multiplier
// bit per cycle, and one 2x2 matrix product is eight modular products.
// An index n >= 3 needs one matrix product per bit of n-1 (squaring) plus
// one per set bit (multiply), minus the final squaring, i.e. up to about
// 2 * INDEX_BITS matrix products. Indices 1 and 2, modulus 0 and index 0
// skip the matrix products. The user must write the modulus register
// through the csr port only while idle; the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
module fibonacci_mod_matrix_power_unit #(
   parameter int INDEX_BITS = 63,
   parameter int MOD_BITS   = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [INDEX_BITS-1:0] req_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [MOD_BITS-1:0]   rsp_fib_value,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [MOD_BITS-1:0]   csr_modulus
);

   import fmmp_pkg::*;

`include "fibonacci_mod_matrix_power_unit_defines.svh"

   localparam int CNT_BITS = $clog2(MOD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MOD_BITS - 1);

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic                  sq_ff, sq_in;        // multiply already done for this bit
   logic [1:0]            entry_ff, entry_in;
   logic                  term_ff, term_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [INDEX_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0]   modulus_ff, modulus_in;
   logic [MOD_BITS-1:0]   acc_ff, acc_in;
   logic [MOD_BITS-1:0]   sum_ff, sum_in;
   logic [MOD_BITS-1:0]   mcand_ff, mcand_in;
   logic [MOD_BITS-1:0]   mplier_ff, mplier_in;
   logic [MOD_BITS-1:0]   r0_ff, r1_ff, r2_ff, r3_ff;
   logic [MOD_BITS-1:0]   r0_in, r1_in, r2_in, r3_in;
   logic [MOD_BITS-1:0]   b0_ff, b1_ff, b2_ff, b3_ff;
   logic [MOD_BITS-1:0]   b0_in, b1_in, b2_in, b3_in;
   logic [MOD_BITS-1:0]   t0_ff, t1_ff, t2_ff, t3_ff;
   logic [MOD_BITS-1:0]   t0_in, t1_in, t2_in, t3_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MOD_BITS-1:0]   result_ff, result_in;

   logic [MOD_BITS-1:0]   one_m;
   logic [1:0]            idx_x, idx_y;
   logic [MOD_BITS-1:0]   x_r, x_b, y_b, x_sel;
   logic [MOD_BITS:0]     mod_ext;
   logic [MOD_BITS:0]     dbl, dbl_red, mac, mac_red;
   logic [MOD_BITS-1:0]   add_a, add_b;
   logic [MOD_BITS:0]     add_s, add_red;

   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fib_value = result_ff;

   assign one_m   = (modulus_ff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
   assign mod_ext = {1'b0, modulus_ff};

   // operand select: X[row, term] * Y[term, col]
   assign idx_x = {entry_ff[1], term_ff};
   assign idx_y = {term_ff, entry_ff[0]};

   always_comb begin
      case (idx_x)
         2'd0:    begin x_r = r0_ff; x_b = b0_ff; end
         2'd1:    begin x_r = r1_ff; x_b = b1_ff; end
         2'd2:    begin x_r = r2_ff; x_b = b2_ff; end
         default: begin x_r = r3_ff; x_b = b3_ff; end
      endcase
      case (idx_y)
         2'd0:    y_b = b0_ff;
         2'd1:    y_b = b1_ff;
         2'd2:    y_b = b2_ff;
         default: y_b = b3_ff;
      endcase
      x_sel = (mode_ff == MODE_MUL) ? x_r : x_b;
   end

   // serial multiplier step: acc = (2 * acc + bit * mcand) mod m
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
      mac     = {1'b0, dbl_red[MOD_BITS-1:0]}
              + (mplier_ff[MOD_BITS-1] ? {1'b0, mcand_ff} : '0);
      mac_red = (mac >= mod_ext) ? mac - mod_ext : mac;
   end

   // shared modular adder
   always_comb begin
      if (state_ff == ST_REDUCE) begin
         add_a = r2_ff;
         add_b = r3_ff;
      end else begin
         add_a = sum_ff;
         add_b = acc_ff;
      end
      add_s   = {1'b0, add_a} + {1'b0, add_b};
      add_red = (add_s >= mod_ext) ? add_s - mod_ext : add_s;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      sq_in        = sq_ff;
      entry_in     = entry_ff;
      term_in      = term_ff;
      cnt_in       = cnt_ff;
      exp_in       = exp_ff;
      modulus_in   = modulus_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      r0_in = r0_ff; r1_in = r1_ff; r2_in = r2_ff; r3_in = r3_ff;
      b0_in = b0_ff; b1_in = b1_ff; b2_in = b2_ff; b3_in = b3_ff;
      t0_in = t0_ff; t1_in = t1_ff; t2_in = t2_ff; t3_in = t3_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) begin
         modulus_in = csr_modulus;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (modulus_ff == '0 || req_index == '0) begin
                  sum_in   = '0;
                  state_in = ST_FINISH;
               end else if (req_index < INDEX_BITS'(3)) begin
                  sum_in   = one_m;
                  state_in = ST_FINISH;
               end else begin
                  r0_in    = one_m;
                  r1_in    = '0;
                  r2_in    = '0;
                  r3_in    = one_m;
                  b0_in    = one_m;
                  b1_in    = one_m;
                  b2_in    = one_m;
                  b3_in    = '0;
                  exp_in   = req_index - INDEX_BITS'(1);
                  sq_in    = 1'b0;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            entry_in = '0;
            term_in  = 1'b0;
            sum_in   = '0;
            if (exp_ff == '0) begin
               state_in = ST_REDUCE;
            end else if (exp_ff[0] && !sq_ff) begin
               mode_in  = MODE_MUL;
               state_in = ST_LOAD;
            end else if (exp_ff == INDEX_BITS'(1)) begin
               // last bit: the square would never be used
               exp_in = '0;
               sq_in  = 1'b0;
            end else begin
               mode_in  = MODE_SQUARE;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mcand_in  = x_sel;
            mplier_in = y_b;
            acc_in    = '0;
            cnt_in    = CNT_LAST;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            acc_in    = mac_red[MOD_BITS-1:0];
            mplier_in = {mplier_ff[MOD_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               state_in = ST_ACCUM;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         ST_ACCUM: begin
            if (!term_ff) begin
               sum_in   = add_red[MOD_BITS-1:0];
               term_in  = 1'b1;
               state_in = ST_LOAD;
            end else begin
               case (entry_ff)
                  2'd0:    t0_in = add_red[MOD_BITS-1:0];
                  2'd1:    t1_in = add_red[MOD_BITS-1:0];
                  2'd2:    t2_in = add_red[MOD_BITS-1:0];
                  default: t3_in = add_red[MOD_BITS-1:0];
               endcase
               sum_in  = '0;
               term_in = 1'b0;
               if (entry_ff == 2'd3) begin
                  state_in = ST_COMMIT;
               end else begin
                  entry_in = entry_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_COMMIT: begin
            if (mode_ff == MODE_MUL) begin
               r0_in = t0_ff; r1_in = t1_ff; r2_in = t2_ff; r3_in = t3_ff;
               sq_in = 1'b1;
            end else begin
               b0_in  = t0_ff; b1_in = t1_ff; b2_in = t2_ff; b3_in = t3_ff;
               exp_in = exp_ff >> 1;
               sq_in  = 1'b0;
            end
            state_in = ST_STEP;
         end
         ST_REDUCE: begin
            // second row applied to (1,1)
            sum_in   = add_red[MOD_BITS-1:0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               result_in    = sum_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MOD_BITS'(MODULUS_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      sq_ff     <= sq_in;
      entry_ff  <= entry_in;
      term_ff   <= term_in;
      cnt_ff    <= cnt_in;
      exp_ff    <= exp_in;
      acc_ff    <= acc_in;
      sum_ff    <= sum_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      r0_ff <= r0_in; r1_ff <= r1_in; r2_ff <= r2_in; r3_ff <= r3_in;
      b0_ff <= b0_in; b1_ff <= b1_in; b2_ff <= b2_in; b3_ff <= b3_in;
      t0_ff <= t0_in; t1_ff <= t1_in; t2_ff <= t2_in; t3_ff <= t3_in;
      result_ff <= result_in;
   end

   `FMMP_ASSERT_NOW(a_result_below_mod, clock, reset, rsp_valid_ff, (result_ff < modulus_ff) || (modulus_ff == '0), "fib_value not reduced")
   `FMMP_ASSERT_NOW(a_acc_below_mod, clock, reset, state_ff == ST_MUL, acc_ff < modulus_ff, "multiplier accumulator not reduced")
   `FMMP_ASSERT_NEXT(a_mul_runs, clock, reset, (state_ff == ST_MUL) && (cnt_ff != '0), state_ff == ST_MUL, "multiplier left early")
   `FMMP_ASSERT_NEXT(a_exp_shift, clock, reset, (state_ff == ST_COMMIT) && (mode_ff == MODE_SQUARE), exp_ff == ($past(exp_ff) >> 1), "exponent not shifted after square")

endmodule
